[rtl/core/indexed_shift_array_core_macros.svh]
// Assertion macros shared by the indexed shift array RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef INDEXED_SHIFT_ARRAY_CORE_MACROS_SVH
`define INDEXED_SHIFT_ARRAY_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ISA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("indexed shift array check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ISA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("indexed shift array check failed");
`else
`define ISA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ISA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/isa_pkg.sv]
// Shared types and codes for the indexed shift array.
// Used by isa_cell, isa_ctrl and indexed_shift_array_core; depends on nothing.
package isa_pkg;

	// Field widths of the request and result items.
	localparam int unsigned OP_W       = 3;
	localparam int unsigned INDEX_W    = 5;
	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 40;

	// Position width covers every cell slot up to the largest supported capacity.
	localparam int unsigned POS_W = 9;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_READ       = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT     = 3'd1;
	localparam logic [OP_W-1:0] OP_ERASE      = 3'd2;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd3;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd5;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd6;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	// Cell update modes broadcast along the chain.
	localparam logic [1:0] MODE_HOLD = 2'd0;
	localparam logic [1:0] MODE_INS  = 2'd1;
	localparam logic [1:0] MODE_DEL  = 2'd2;

	// Command seen by every cell in the same cycle.
	typedef struct packed {
		logic [1:0]       mode;
		logic [POS_W-1:0] pos;
	} isa_cmd_t;

endpackage

[rtl/core/isa_cell.sv]
// One storage cell of the shift chain: holds one element and takes a new
// value, its left neighbor or its right neighbor. Depends on isa_pkg.
module isa_cell #(
	parameter int unsigned ELEMENT_WIDTH = 32,
	parameter int unsigned IDX           = 0
) (
	input  logic                     clk,
	input  isa_pkg::isa_cmd_t        cmd,
	input  logic [ELEMENT_WIDTH-1:0] new_value,
	input  logic [ELEMENT_WIDTH-1:0] left_data,
	input  logic [ELEMENT_WIDTH-1:0] right_data,
	output logic [ELEMENT_WIDTH-1:0] data
);
	import isa_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	logic [ELEMENT_WIDTH-1:0] data_q;

	// Insert opens a gap at pos; erase closes the gap at pos.
	always_ff @(posedge clk) begin
		case (cmd.mode)
			MODE_INS: begin
				if (MY_POS == cmd.pos) begin
					data_q <= new_value;
				end else if (MY_POS > cmd.pos) begin
					data_q <= left_data;
				end
			end
			MODE_DEL: begin
				if (MY_POS >= cmd.pos) begin
					data_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

[rtl/core/isa_ctrl.sv]
// Request decode, checks and element count for the indexed shift array.
// Drives the command broadcast to the cell chain. Depends on isa_pkg.
`include "indexed_shift_array_core_macros.svh"
module isa_ctrl #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [isa_pkg::OP_W-1:0]            op,
	input  logic [isa_pkg::INDEX_W-1:0]         index,
	output isa_pkg::isa_cmd_t                   cmd,
	output logic [isa_pkg::STATUS_W-1:0]        status,
	output logic [isa_pkg::COUNT_W-1:0]         count
);
	import isa_pkg::*;

	localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W  = (FILL_W > INDEX_W) ? FILL_W : INDEX_W;
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(CAPACITY);

	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_d;
	logic [CMP_W-1:0]  fill_x;
	logic [CMP_W-1:0]  index_x;
	logic              is_full;
	logic              is_empty;
	isa_cmd_t          cmd_raw;

	assign fill_x   = CMP_W'(fill_q);
	assign index_x  = CMP_W'(index);
	assign is_full  = (fill_q == FULL_FILL);
	assign is_empty = (fill_q == '0);

	// Check the request and pick the chain command and the next count.
	always_comb begin
		status       = ST_OK;
		fill_d       = fill_q;
		cmd_raw.mode = MODE_HOLD;
		cmd_raw.pos  = '0;
		case (op)
			OP_READ: begin
				if (index_x >= fill_x) begin
					status = ST_RANGE;
				end
			end
			OP_INSERT: begin
				if (is_full) begin
					status = ST_FULL;
				end else if (index_x > fill_x) begin
					status = ST_RANGE;
				end else begin
					cmd_raw.mode = MODE_INS;
					cmd_raw.pos  = POS_W'(index);
					fill_d       = fill_q + 1'b1;
				end
			end
			OP_ERASE: begin
				if (index_x >= fill_x) begin
					status = ST_RANGE;
				end else begin
					cmd_raw.mode = MODE_DEL;
					cmd_raw.pos  = POS_W'(index);
					fill_d       = fill_q - 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (is_full) begin
					status = ST_FULL;
				end else begin
					cmd_raw.mode = MODE_INS;
					cmd_raw.pos  = POS_W'(fill_q);
					fill_d       = fill_q + 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				if (is_full) begin
					status = ST_FULL;
				end else begin
					cmd_raw.mode = MODE_INS;
					fill_d       = fill_q + 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					fill_d = fill_q - 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					cmd_raw.mode = MODE_DEL;
					fill_d       = fill_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// The cells only move on an accepted request.
	always_comb begin
		cmd = cmd_raw;
		if (!accept) begin
			cmd.mode = MODE_HOLD;
		end
	end

	assign count = COUNT_W'(fill_d);

	// Element count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_d;
		end
	end

	`ISA_ASSERT_IMPLY(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FULL_FILL)
	`ISA_ASSERT_IMPLY(a_full_only_at_cap, clk, arst_n, status == ST_FULL, is_full)
	`ISA_ASSERT_NEXT(a_reject_keeps_fill, clk, arst_n, accept && (status != ST_OK), $stable(fill_q))
	`ISA_ASSERT_NEXT(a_insert_grows, clk, arst_n, accept && (cmd_raw.mode == MODE_INS), fill_q == $past(fill_q) + 1'b1)

endmodule

[rtl/core/indexed_shift_array_core.sv]
// Top level of the indexed shift array: stream ports, cell chain and result register.
// Depends on isa_pkg, isa_ctrl, isa_cell and the assertion macro header.
//
// A dense ordered array of up to CAPACITY elements held in a row of cells. Every
// request (read, insert, erase, push or pop at either end) is applied by all cells
// updating together from their neighbors, so one request is accepted per clock
// and its result is valid on the master side the cycle after acceptance. The only
// thing that slows the input is a full result register that the downstream side
// has not taken. Cells have no reset; the element count clears on reset and no
// clearing pass is needed, so requests are taken right after reset. A read reports
// only stored entries; rejected requests leave the array and the count unchanged.
`include "indexed_shift_array_core_macros.svh"
module indexed_shift_array_core #(
	parameter int unsigned CAPACITY      = 16,
	parameter int unsigned ELEMENT_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata, low to high: op[2:0], index[7:3], value[39:8]
	input  logic [isa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// tdata, low to high: read_value[31:0], count[36:32], status[38:37], zero[39]
	output logic [isa_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import isa_pkg::*;

	logic                     s_accept;
	logic [OP_W-1:0]          op;
	logic [INDEX_W-1:0]       index;
	logic [VALUE_W-1:0]       value;
	logic [ELEMENT_WIDTH-1:0] new_elem;
	logic [ELEMENT_WIDTH-1:0] cell_data  [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] left_data  [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] right_data [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] hit_data   [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] rd_elem;
	logic [VALUE_W-1:0]       rd_word;
	isa_cmd_t                 cmd;
	logic [STATUS_W-1:0]      status;
	logic [COUNT_W-1:0]       count;
	logic                     m_valid_q;
	logic [VALUE_W-1:0]       rd_q;
	logic [COUNT_W-1:0]       count_q;
	logic [STATUS_W-1:0]      status_q;

	// Request fields.
	assign op    = s_axis_tdata[OP_W-1:0];
	assign index = s_axis_tdata[OP_W+INDEX_W-1:OP_W];
	assign value = s_axis_tdata[OP_W+INDEX_W+VALUE_W-1:OP_W+INDEX_W];

	// A new request is taken whenever the result register is free or draining.
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// Fit the incoming value to the element width and the element to the result word.
	generate
		if (ELEMENT_WIDTH >= VALUE_W) begin : g_wide
			assign new_elem = ELEMENT_WIDTH'(value);
			assign rd_word  = rd_elem[VALUE_W-1:0];
		end else begin : g_narrow
			assign new_elem = value[ELEMENT_WIDTH-1:0];
			assign rd_word  = VALUE_W'(rd_elem);
		end
	endgenerate

	isa_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (s_accept),
		.op     (op),
		.index  (index),
		.cmd    (cmd),
		.status (status),
		.count  (count)
	);

	// Cell chain; the ends see zero on the left and their own data on the right.
	generate
		for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				assign left_data[gi] = '0;
			end else begin : g_mid_left
				assign left_data[gi] = cell_data[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_data[gi] = cell_data[gi];
			end else begin : g_mid_right
				assign right_data[gi] = cell_data[gi+1];
			end

			isa_cell #(
				.ELEMENT_WIDTH (ELEMENT_WIDTH),
				.IDX           (gi)
			) u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.new_value  (new_elem),
				.left_data  (left_data[gi]),
				.right_data (right_data[gi]),
				.data       (cell_data[gi])
			);

			// Each cell drives the read bus only when its slot is addressed.
			assign hit_data[gi] = (POS_W'(index) == POS_W'(gi)) ? cell_data[gi] : '0;
		end
	endgenerate

	// Read select gathers the addressed cell.
	always_comb begin
		rd_elem = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_elem = rd_elem | hit_data[i];
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_accept) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result payload; a value is returned only for a successful read.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			rd_q     <= ((op == OP_READ) && (status == ST_OK)) ? rd_word : '0;
			count_q  <= count;
			status_q <= status;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, status_q, count_q, rd_q};

	`ISA_ASSERT_NEXT(a_result_follows, clk, arst_n, s_accept, m_axis_tvalid)
	`ISA_ASSERT_NEXT(a_count_reported, clk, arst_n, s_accept, m_axis_tdata[36:32] == $past(count))
	`ISA_ASSERT_IMPLY(a_reject_no_move, clk, arst_n, status != ST_OK, cmd.mode == MODE_HOLD)

endmodule

[verif/isa_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for the indexed shift array: watches both stream channels,
// predicts each result from accepted requests and compares field by field.
// Depends on isa_pkg for the field widths, operation codes and status codes.
module isa_result_checker
	import isa_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	input  logic [OUT_DATA_W-1:0]     m_axis_tdata,
	output int unsigned               mismatches,
	output int unsigned               pending
);

	localparam int unsigned SLOTS = 16;
	localparam int unsigned REPORT_LIMIT = 10;

	// Request layout, highest field first so that it lines up with tdata.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
		logic [OP_W-1:0]    op;
	} request_t;

	// Result layout, including the padding bit that must read as zero.
	typedef struct packed {
		logic                 pad;
		logic [STATUS_W-1:0]  status;
		logic [COUNT_W-1:0]   count;
		logic [VALUE_W-1:0]   read_value;
	} result_t;

	// Shadow copy of the array contents and element count.
	logic [VALUE_W-1:0] shadow_cells [0:SLOTS-1];
	logic [COUNT_W-1:0] shadow_fill;
	result_t            expected_results [$];

	// Opens a slot at pos by moving every later element up one place.
	function automatic void open_slot(input logic [COUNT_W-1:0] pos,
			input logic [VALUE_W-1:0] value);
		for (int i = shadow_fill; i > pos; i--) begin
			shadow_cells[i] = shadow_cells[i-1];
		end
		shadow_cells[pos] = value;
		shadow_fill++;
	endfunction

	// Closes the slot at pos by moving every later element down one place.
	function automatic void close_slot(input logic [COUNT_W-1:0] pos);
		for (int i = pos; i + 1 < shadow_fill; i++) begin
			shadow_cells[i] = shadow_cells[i+1];
		end
		shadow_fill--;
	endfunction

	// Applies one request to the shadow array and returns the result it yields.
	function automatic result_t apply_request(input request_t req);
		result_t res;
		res = '0;
		res.status = ST_OK;
		case (req.op)
			OP_READ: begin
				if (req.index < shadow_fill) res.read_value = shadow_cells[req.index];
				else res.status = ST_RANGE;
			end
			OP_INSERT: begin
				if (shadow_fill >= SLOTS) res.status = ST_FULL;
				else if (req.index > shadow_fill) res.status = ST_RANGE;
				else open_slot(req.index, req.value);
			end
			OP_ERASE: begin
				if (req.index < shadow_fill) close_slot(req.index);
				else res.status = ST_RANGE;
			end
			OP_PUSH_BACK: begin
				if (shadow_fill >= SLOTS) res.status = ST_FULL;
				else open_slot(shadow_fill, req.value);
			end
			OP_PUSH_FRONT: begin
				if (shadow_fill >= SLOTS) res.status = ST_FULL;
				else open_slot('0, req.value);
			end
			OP_POP_BACK: begin
				if (shadow_fill == 0) res.status = ST_EMPTY;
				else shadow_fill--;
			end
			OP_POP_FRONT: begin
				if (shadow_fill == 0) res.status = ST_EMPTY;
				else close_slot('0);
			end
			default: begin
				// The unused operation code changes nothing and reports ok.
			end
		endcase
		res.count = shadow_fill;
		return res;
	endfunction

	// Both handshakes are sampled at the rising edge, results before requests.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			shadow_fill = '0;
			expected_results.delete();
			mismatches = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result with no request waiting: %h", got);
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("mismatch: expected value %h count %0d status %0d pad %b,",
								want.read_value, want.count, want.status, want.pad,
								" got value %h count %0d status %0d pad %b",
								got.read_value, got.count, got.status, got.pad);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.insert(expected_results.size(),
					apply_request(request_t'(s_axis_tdata)));
		end
		pending = expected_results.size();
	end

endmodule

[verif/indexed_shift_array_core_test.sv]
`timescale 1ns / 100ps
// Top of the indexed shift array testbench: clock, reset, request stimulus and verdict.
// Depends on isa_pkg, the indexed_shift_array_core RTL and isa_result_checker.
module indexed_shift_array_core_test;
	import isa_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int unsigned RANDOM_REQUESTS = 850;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	int unsigned           mismatches;
	int unsigned           pending;
	int unsigned           burst_left;

	indexed_shift_array_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	isa_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// Offers one request until it is taken; once the burst count runs out, ends the burst with a random gap.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] index,
			input logic [VALUE_W-1:0] value);
		int unsigned gap;
		s_axis_tdata <= {value, index, op};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 7);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				s_axis_tdata <= {$urandom, 8'($urandom)};
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Receiver: a long hold-off first so the block backs up, then mixed stall styles.
	initial begin
		int unsigned style;
		int unsigned span;
		m_axis_tready = 1'b0;
		wait (arst_n);
		repeat (150) @(posedge clk);
		forever begin
			style = $urandom_range(0, 9);
			span = (style == 0) ? 200 : $urandom_range(5, 60);
			repeat (span) begin
				@(posedge clk);
				case (style)
					0: m_axis_tready <= 1'b0;
					1, 2, 3: m_axis_tready <= 1'b1;
					4, 5, 6: m_axis_tready <= ($urandom_range(0, 3) != 0);
					default: m_axis_tready <= ($urandom_range(0, 1) != 0);
				endcase
			end
		end
	end

	// Reset, directed requests, random requests, drain and verdict.
	initial begin
		int unsigned pick;
		int unsigned phase_left;
		bit grow;
		logic [OP_W-1:0] op;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		burst_left = 1000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Every rejection on an empty array, and the unused code.
		send_request(OP_READ, 5'd0, 32'h0000_0000);
		send_request(OP_ERASE, 5'd0, 32'h0000_0000);
		send_request(OP_POP_BACK, 5'd0, 32'h0000_0000);
		send_request(OP_POP_FRONT, 5'd0, 32'h0000_0000);
		send_request(OP_INSERT, 5'd1, 32'h1111_1111);
		send_request(OP_UNUSED, 5'd31, 32'hffff_ffff);

		// Extreme values at both ends and inserts at the front, the end and the middle.
		send_request(OP_PUSH_FRONT, 5'd0, 32'h8000_0000);
		send_request(OP_PUSH_BACK, 5'd0, 32'h7fff_ffff);
		send_request(OP_INSERT, 5'd0, 32'h0000_0000);
		send_request(OP_INSERT, 5'd3, 32'hffff_ffff);
		send_request(OP_INSERT, 5'd1, 32'h1234_5678);
		send_request(OP_READ, 5'd0, 32'h0000_0000);
		send_request(OP_READ, 5'd4, 32'h0000_0000);
		send_request(OP_READ, 5'd5, 32'h0000_0000);
		send_request(OP_ERASE, 5'd2, 32'h0000_0000);

		// Fill to capacity, then try every growing request on a full array.
		repeat (12) send_request(OP_PUSH_BACK, 5'd0, $urandom);
		send_request(OP_PUSH_BACK, 5'd0, 32'h5555_5555);
		send_request(OP_PUSH_FRONT, 5'd0, 32'haaaa_aaaa);
		send_request(OP_INSERT, 5'd31, 32'h0f0f_0f0f);

		// Random requests in phases that lean toward growing or shrinking the array.
		burst_left = $urandom_range(1, 24);
		phase_left = 0;
		grow = 1'b1;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 60);
				grow = ~grow;
			end
			phase_left--;

			pick = $urandom_range(0, 99);
			if (pick < 3) op = OP_UNUSED;
			else if (pick < 18) op = OP_READ;
			else if (grow) begin
				if (pick < 45) op = OP_INSERT;
				else if (pick < 60) op = OP_PUSH_BACK;
				else if (pick < 75) op = OP_PUSH_FRONT;
				else if (pick < 82) op = OP_ERASE;
				else if (pick < 91) op = OP_POP_BACK;
				else op = OP_POP_FRONT;
			end else begin
				if (pick < 30) op = OP_INSERT;
				else if (pick < 38) op = OP_PUSH_BACK;
				else if (pick < 46) op = OP_PUSH_FRONT;
				else if (pick < 68) op = OP_ERASE;
				else if (pick < 84) op = OP_POP_BACK;
				else op = OP_POP_FRONT;
			end

			// Mostly plausible positions, sometimes anything the field holds.
			if ($urandom_range(0, 99) < 85) index = INDEX_W'($urandom_range(0, 16));
			else index = INDEX_W'($urandom_range(0, 31));

			case ($urandom_range(0, 11))
				0: value = 32'h8000_0000;
				1: value = 32'h7fff_ffff;
				2: value = 32'hffff_ffff;
				3: value = 32'h0000_0000;
				default: value = $urandom;
			endcase

			send_request(op, index, value);
		end

		// Drain the outstanding results, then keep watching for stray ones before the verdict.
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
